@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// implication checked in the same cycle
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ssi_pkg.sv @@
// ----------------------------------------------------------------------------
// ssi_pkg
// widths and types shared by the segment intersection block and its checker
// ----------------------------------------------------------------------------
package ssi_pkg;

  // width of each coordinate field on the bus
  localparam int FIELD_W     = 16;
  // coordinate bits actually used, sign-extended from the top one
  localparam int COORD_WIDTH = 16;
  // number of coordinate fields in one input item
  localparam int NUM_FIELDS  = 8;

  // bus widths
  localparam int IN_W  = FIELD_W * NUM_FIELDS;
  localparam int OUT_W = 8;

  // arithmetic widths: difference, product, difference of products
  localparam int RAW_W  = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;

  // pipeline depth including the output register
  localparam int DEPTH   = 4;
  localparam int DEPTH_W = $clog2(DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [SUM_W-1:0]       sum_t;
  typedef logic [DEPTH_W-1:0]            depth_cnt_t;

endpackage

@@ src/segment_segment_intersect.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect
// exact integer test of whether two closed line segments cross at one point
// ----------------------------------------------------------------------------
// Takes one pair of segments per item and returns one flag per item, set when
// the determinant of the two directions is nonzero and the crossing point lies
// on both segments, endpoints included. Parallel, collinear and point-like
// segments report 0. The datapath is a four-stage pipeline (differences,
// six signed multipliers, product differences, range compares into the output
// register), so it accepts one item every cycle while the output side is not
// stalled, and offers each result from the output register. Stalls squeeze
// out empty stages before holding the input side.
module segment_segment_intersect (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // seg_a_x_start, seg_a_y_start, seg_a_x_end, seg_a_y_end,
  // seg_b_x_start, seg_b_y_start, seg_b_x_end, seg_b_y_end (16 bits each)
  input  logic [ssi_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // segments_meet in bit 0, bits above are zero
  output logic [ssi_pkg::OUT_W-1:0] m_axis_tdata
);

  // low coordinate bits of a field, sign-extended
  function automatic ssi_pkg::coord_t coord_of(input logic [ssi_pkg::FIELD_W-1:0] raw);
    logic [ssi_pkg::RAW_W-1:0] wide;
    wide = ssi_pkg::RAW_W'(raw);
    return ssi_pkg::coord_t'(wide[ssi_pkg::COORD_WIDTH-1:0]);
  endfunction

  // true when num / den lies in [0, 1], den nonzero
  function automatic logic in_unit(input ssi_pkg::sum_t num, input ssi_pkg::sum_t den);
    logic pos;
    pos = !den[ssi_pkg::SUM_W-1];
    if (pos) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  // stage valid bits and per-stage ready
  logic [ssi_pkg::DEPTH-1:0] valid;
  logic [ssi_pkg::DEPTH-1:0] ready;

  // stage handshake chain, a stage moves when it is empty or its successor moves
  always_comb begin
    ready[3] = !valid[3] || m_axis_tready;
    ready[2] = !valid[2] || ready[3];
    ready[1] = !valid[1] || ready[2];
    ready[0] = !valid[0] || ready[1];
  end

  assign s_axis_tready = ready[0];

  // unpack the coordinates
  ssi_pkg::coord_t x1, y1, x2, y2, x3, y3, x4, y4;
  always_comb begin
    x1 = coord_of(s_axis_tdata[0*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    y1 = coord_of(s_axis_tdata[1*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    x2 = coord_of(s_axis_tdata[2*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    y2 = coord_of(s_axis_tdata[3*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    x3 = coord_of(s_axis_tdata[4*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    y3 = coord_of(s_axis_tdata[5*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    x4 = coord_of(s_axis_tdata[6*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
    y4 = coord_of(s_axis_tdata[7*ssi_pkg::FIELD_W +: ssi_pkg::FIELD_W]);
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) valid[0] <= s_axis_tvalid;
      if (ready[1]) valid[1] <= valid[0];
      if (ready[2]) valid[2] <= valid[1];
      if (ready[3]) valid[3] <= valid[2];
    end
  end

  // stage 1: direction and offset differences
  ssi_pkg::diff_t dax, day, dbx, dby, dcx, dcy;
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      dax <= ssi_pkg::DIFF_W'(x1) - ssi_pkg::DIFF_W'(x2);
      day <= ssi_pkg::DIFF_W'(y1) - ssi_pkg::DIFF_W'(y2);
      dbx <= ssi_pkg::DIFF_W'(x3) - ssi_pkg::DIFF_W'(x4);
      dby <= ssi_pkg::DIFF_W'(y3) - ssi_pkg::DIFF_W'(y4);
      dcx <= ssi_pkg::DIFF_W'(x1) - ssi_pkg::DIFF_W'(x3);
      dcy <= ssi_pkg::DIFF_W'(y1) - ssi_pkg::DIFF_W'(y3);
    end
  end

  // stage 2: the six cross products
  ssi_pkg::prod_t den_p, den_q, tn_p, tn_q, un_p, un_q;
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      den_p <= ssi_pkg::PROD_W'(dax) * ssi_pkg::PROD_W'(dby);
      den_q <= ssi_pkg::PROD_W'(day) * ssi_pkg::PROD_W'(dbx);
      tn_p  <= ssi_pkg::PROD_W'(dcx) * ssi_pkg::PROD_W'(dby);
      tn_q  <= ssi_pkg::PROD_W'(dcy) * ssi_pkg::PROD_W'(dbx);
      un_p  <= ssi_pkg::PROD_W'(day) * ssi_pkg::PROD_W'(dcx);
      un_q  <= ssi_pkg::PROD_W'(dax) * ssi_pkg::PROD_W'(dcy);
    end
  end

  // stage 3: determinant and the two parameter numerators
  ssi_pkg::sum_t den, tn, un;
  always_ff @(posedge clk) begin
    if (ready[2]) begin
      den <= ssi_pkg::SUM_W'(den_p) - ssi_pkg::SUM_W'(den_q);
      tn  <= ssi_pkg::SUM_W'(tn_p) - ssi_pkg::SUM_W'(tn_q);
      un  <= ssi_pkg::SUM_W'(un_p) - ssi_pkg::SUM_W'(un_q);
    end
  end

  // stage 4: both parameters in [0, 1] and lines not parallel
  logic meet;
  always_ff @(posedge clk) begin
    if (ready[3]) begin
      meet <= (den != 0) && in_unit(tn, den) && in_unit(un, den);
    end
  end

  assign m_axis_tvalid = valid[3];
  assign m_axis_tdata  = ssi_pkg::OUT_W'(meet);

endmodule

@@ src/ssi_checker.sv @@
// ----------------------------------------------------------------------------
// ssi_checker
// port-level checks on the segment intersection pipeline, bound to the top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssi_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [ssi_pkg::OUT_W-1:0] m_axis_tdata
);

  logic in_fire;
  logic out_fire;
  ssi_pkg::depth_cnt_t inflight;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // items taken but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + ssi_pkg::DEPTH_W'(in_fire) - ssi_pkg::DEPTH_W'(out_fire);
    end
  end

  // a stalled result holds its value
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // an open output side never back-pressures the input
  `ASSERT_IMPL(a_ready_through, m_axis_tready, s_axis_tready, "input stalled with output ready")

  // no result without an item in flight
  `ASSERT_IMPL(a_no_phantom, m_axis_tvalid, inflight != 0, "result with no item in flight")

  // never more items in flight than pipeline stages
  `ASSERT_ALWAYS(a_depth_bound, inflight <= ssi_pkg::DEPTH_W'(ssi_pkg::DEPTH), "too many items in flight")

  // padding bits of the result stay zero
  `ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[ssi_pkg::OUT_W-1:1] == '0, "nonzero result padding")

endmodule

bind segment_segment_intersect ssi_checker u_ssi_checker (.*);

@@ verif/segment_segment_intersect_checker.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect_checker
// watches both streams of the segment intersection block and scores results
// ----------------------------------------------------------------------------
// Every item taken on the input stream is run through an exact integer model
// of the crossing test, and the predicted flag is queued. Every item taken on
// the output stream is compared with the oldest queued flag. The number of
// mismatches and the number of flags still waiting go back to the top.
module segment_segment_intersect_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  input  logic                      s_axis_tready,
  input  logic [ssi_pkg::IN_W-1:0]  s_axis_tdata,
  input  logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  input  logic [ssi_pkg::OUT_W-1:0] m_axis_tdata,
  output int                        mismatches,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // field positions in the input item, lowest first
  localparam int AX_START = 0;
  localparam int AY_START = 1;
  localparam int AX_END   = 2;
  localparam int AY_END   = 3;
  localparam int BX_START = 4;
  localparam int BY_START = 5;
  localparam int BX_END   = 6;
  localparam int BY_END   = 7;

  bit expected_meet_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // num/den within [0, 1], den nonzero
  function automatic bit ratio_in_unit(input longint num, input longint den);
    if (den > 0) return (num >= 0) && (num <= den);
    return (num <= 0) && (num >= den);
  endfunction

  // exact crossing test on one segment pair
  function automatic bit segments_cross(input logic [ssi_pkg::IN_W-1:0] pair);
    longint c [ssi_pkg::NUM_FIELDS];
    longint a_dx, a_dy, b_dx, b_dy, s_dx, s_dy;
    longint det, t_num, u_num;
    // low coordinate bits only, sign-extended
    for (int k = 0; k < ssi_pkg::NUM_FIELDS; k++)
      c[k] = longint'(ssi_pkg::coord_t'(
                 pair[k*ssi_pkg::FIELD_W +: ssi_pkg::COORD_WIDTH]));
    a_dx = c[AX_START] - c[AX_END];
    a_dy = c[AY_START] - c[AY_END];
    b_dx = c[BX_START] - c[BX_END];
    b_dy = c[BY_START] - c[BY_END];
    s_dx = c[AX_START] - c[BX_START];
    s_dy = c[AY_START] - c[BY_START];
    det  = a_dx * b_dy - a_dy * b_dx;
    // parallel, collinear or point-like never meet
    if (det == 0) return 1'b0;
    t_num = s_dx * b_dy - s_dy * b_dx;
    u_num = a_dy * s_dx - a_dx * s_dy;
    return ratio_in_unit(t_num, det) && ratio_in_unit(u_num, det);
  endfunction

  // score outputs before queueing the new input so an item never meets itself
  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_meet_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result 0x%0h", m_axis_tdata));
        end else begin
          want = expected_meet_q.pop_front();
          if (m_axis_tdata[0] !== want)
            report_mismatch($sformatf("segments_meet %b, expected %b",
                                      m_axis_tdata[0], want));
          if (m_axis_tdata[ssi_pkg::OUT_W-1:1] !== '0)
            report_mismatch($sformatf("padding bits 0x%0h not zero",
                                      m_axis_tdata[ssi_pkg::OUT_W-1:1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_meet_q.push_back(segments_cross(s_axis_tdata));
    end
    pending <= expected_meet_q.size();
  end

endmodule

@@ verif/segment_segment_intersect_test.sv @@
// ----------------------------------------------------------------------------
// segment_segment_intersect_test
// stream test of the segment intersection block
// ----------------------------------------------------------------------------
// Drives hand-picked segment pairs (crossings, endpoint touches, parallel and
// collinear pairs, point-like segments, axis-aligned and full-scale
// coordinates), then random pairs shaped toward crossings and edge cases.
// Both sides idle at random except in one quiet stretch, and the output side
// holds off once for a long while so the pipeline fills and stalls its input.
// The checker beside the block predicts and compares every result.
module segment_segment_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_PCT     = 28;
  localparam int QUIET_FROM   = 200;
  localparam int QUIET_TO     = 500;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [ssi_pkg::IN_W-1:0]  s_axis_tdata = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [ssi_pkg::OUT_W-1:0] m_axis_tdata;

  int mismatches;
  int pending;
  int sent_count  = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  always #6 clk = ~clk;

  segment_segment_intersect dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  segment_segment_intersect_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  function automatic bit quiet_stretch();
    return (sent_count >= QUIET_FROM) && (sent_count < QUIET_TO);
  endfunction

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // segment a then segment b, first field in the low bits
  function automatic logic [ssi_pkg::IN_W-1:0] pack_pair(input int ax0, input int ay0,
                                                         input int ax1, input int ay1,
                                                         input int bx0, input int by0,
                                                         input int bx1, input int by1);
    return {ssi_pkg::FIELD_W'(by1), ssi_pkg::FIELD_W'(bx1),
            ssi_pkg::FIELD_W'(by0), ssi_pkg::FIELD_W'(bx0),
            ssi_pkg::FIELD_W'(ay1), ssi_pkg::FIELD_W'(ax1),
            ssi_pkg::FIELD_W'(ay0), ssi_pkg::FIELD_W'(ax0)};
  endfunction

  // coordinate biased toward the ends of the range
  function automatic int edge_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return rand_between(-32768, 32767);
    endcase
  endfunction

  // random pair, weighted toward crossings, touches and degenerate geometry
  function automatic logic [ssi_pkg::IN_W-1:0] random_pair();
    int px, py, adx, ady, bdx, bdy, ka, ma, kb, mb, ox, oy;
    int pick;
    logic [ssi_pkg::IN_W-1:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      // full range, every bit free
      for (int k = 0; k < ssi_pkg::IN_W / 32; k++) raw[k*32 +: 32] = $urandom();
      return raw;
    end else if (pick < 45) begin
      // tiny box: lots of parallel, collinear and touching pairs
      return pack_pair(rand_between(-8, 8), rand_between(-8, 8),
                       rand_between(-8, 8), rand_between(-8, 8),
                       rand_between(-8, 8), rand_between(-8, 8),
                       rand_between(-8, 8), rand_between(-8, 8));
    end else if (pick < 65) begin
      // lines through one point, endpoints may sit on it; b's start is sometimes nudged by one
      px  = rand_between(-8000, 8000);
      py  = rand_between(-8000, 8000);
      adx = rand_between(-200, 200);
      ady = rand_between(-200, 200);
      bdx = rand_between(-200, 200);
      bdy = rand_between(-200, 200);
      ka  = rand_between(0, 20);
      ma  = rand_between(0, 20);
      kb  = rand_between(0, 20);
      mb  = rand_between(0, 20);
      ox  = ($urandom_range(0, 3) == 0) ? rand_between(-1, 1) : 0;
      oy  = ($urandom_range(0, 3) == 0) ? rand_between(-1, 1) : 0;
      return pack_pair(px - ka * adx, py - ka * ady, px + ma * adx, py + ma * ady,
                       px - kb * bdx + ox, py - kb * bdy + oy,
                       px + mb * bdx, py + mb * bdy);
    end else if (pick < 75) begin
      // same direction: parallel, or collinear when b starts on line a
      px  = rand_between(-4000, 4000);
      py  = rand_between(-4000, 4000);
      adx = rand_between(-100, 100);
      ady = rand_between(-100, 100);
      ka  = rand_between(-10, 10);
      kb  = rand_between(-10, 10);
      mb  = rand_between(-10, 10);
      if ($urandom_range(0, 1)) begin
        ox = ka * adx;
        oy = ka * ady;
      end else begin
        ox = rand_between(-500, 500);
        oy = rand_between(-500, 500);
      end
      return pack_pair(px, py, px + kb * adx, py + kb * ady,
                       px + ox, py + oy, px + ox + mb * adx, py + oy + mb * ady);
    end else if (pick < 90) begin
      // vertical against horizontal, small or full scale
      if ($urandom_range(0, 1)) begin
        px = rand_between(-20, 20);
        py = rand_between(-20, 20);
        return pack_pair(px, rand_between(-20, 20), px, rand_between(-20, 20),
                         rand_between(-20, 20), py, rand_between(-20, 20), py);
      end
      px = edge_coord();
      py = edge_coord();
      return pack_pair(px, edge_coord(), px, edge_coord(),
                       edge_coord(), py, edge_coord(), py);
    end
    return pack_pair(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord());
  endfunction

  // offer one item, idling first at random, and wait until it is taken
  task automatic send_item(input logic [ssi_pkg::IN_W-1:0] pair);
    int gap;
    gap = 0;
    if (!quiet_stretch())
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pair;
    do @(posedge clk); while (!s_axis_tready);
    sent_count <= sent_count + 1;
  endtask

  // output side: random stalls, one long hold-off, a quiet stretch
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= quiet_stretch() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // plain crossing, both orientations
    send_item(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
    send_item(pack_pair(10, 10, 0, 0, 0, 10, 10, 0));
    // lines cross outside segment a
    send_item(pack_pair(0, 0, 1, 0, 5, -1, 5, 1));
    // parallel, collinear overlapping, collinear disjoint
    send_item(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));
    send_item(pack_pair(0, 0, 10, 0, 5, 0, 15, 0));
    send_item(pack_pair(0, 0, 10, 10, 20, 20, 30, 30));
    // point-like segment on the other one, and two equal points
    send_item(pack_pair(3, 3, 3, 3, 0, 0, 6, 6));
    send_item(pack_pair(4, -4, 4, -4, 4, -4, 4, -4));
    // touching end to end, and a tee on the middle of a
    send_item(pack_pair(0, 0, 10, 0, 10, 0, 10, 10));
    send_item(pack_pair(0, 0, 10, 0, 5, 0, 5, 7));
    // vertical against horizontal: hit, and miss by one
    send_item(pack_pair(5, -5, 5, 5, -5, 0, 5, 0));
    send_item(pack_pair(5, -5, 5, 5, 6, 0, 10, 0));
    // full-scale diagonals
    send_item(pack_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    // full-scale vertical and horizontal, touching and just short
    send_item(pack_pair(32767, -32768, 32767, 32767, -32768, 0, 32767, 0));
    send_item(pack_pair(32767, -32768, 32767, 32767, -32768, 0, 32766, 0));
    send_item(pack_pair(-32768, -32768, -32768, 32767, -32768, 32767, 32767, 32767));
    // all fields at one extreme
    send_item(pack_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(pack_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                        -32768));
    send_item(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    // steep near-vertical crossing
    send_item(pack_pair(0, -32768, 1, 32767, -32768, 1, 32767, -1));

    for (int n = 0; n < RANDOM_ITEMS; n++) send_item(random_pair());
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * ssi_pkg::DEPTH) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
